// File: hdl/stable_priority_sorted_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stable priority sorted queue
// Shorthand for clocked checks that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_SORTED_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_SORTED_QUEUE_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define SPSQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SPSQ_ASSERT_IMPLY(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/spsq_pkg.sv
// ---------------------------------------------------------------------------
// Stable priority sorted queue package
// Sizes, codes and the structs shared by the cell chain and the top level.
// ---------------------------------------------------------------------------
package spsq_pkg;

  localparam int ENTRIES  = 16;
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 8;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int ID_COUNT = 1 << ID_W;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_DUP    = 2'd2,
    STATUS_ABSENT = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  // Contents of one cell.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cell_data_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              add_en;
    logic              remove_en;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cell_ctl_t;

endpackage

// File: hdl/spsq_cell.sv
// ---------------------------------------------------------------------------
// Queue cell
// Holds one slot of the sorted queue and shifts toward either neighbor.
// ---------------------------------------------------------------------------
module spsq_cell
  import spsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_data_t left_d,
  input  logic       left_gt,
  input  cell_data_t right_d,
  input  logic       passed_in,
  output cell_data_t own_d,
  output logic       own_gt,
  output logic       passed_out
);

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              match;

  assign own_d      = '{valid: valid_r, id: id_r, prio: prio_r};
  // An empty slot sorts after everything, so the new entry lands after its equals.
  assign own_gt     = !valid_r || (prio_r > ctl.prio);
  assign match      = valid_r && (id_r == ctl.id);
  assign passed_out = passed_in | match;

  always_comb begin
    priority if (ctl.add_en && left_gt) begin
      valid_nxt = left_d.valid;
      id_nxt    = left_d.id;
      prio_nxt  = left_d.prio;
    end else if (ctl.add_en && own_gt) begin
      valid_nxt = 1'b1;
      id_nxt    = ctl.id;
      prio_nxt  = ctl.prio;
    end else if (ctl.remove_en && passed_out) begin
      valid_nxt = right_d.valid;
      id_nxt    = right_d.id;
      prio_nxt  = right_d.prio;
    end else begin
      valid_nxt = valid_r;
      id_nxt    = id_r;
      prio_nxt  = prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// File: hdl/stable_priority_sorted_queue.sv
// ---------------------------------------------------------------------------
// Stable priority sorted queue
// Chain of cells keeping entry identifiers sorted by ascending priority.
// ---------------------------------------------------------------------------
// Usage: each transfer on the in_ channel is one command. in_tuser selects
// add (0) or remove (1); in_tdata carries the identifier and, for an add,
// its priority. Entries of equal priority keep their arrival order.
// Every command yields exactly one transfer on the out_ channel with the
// status, the head entry after the command and the entry count.
// Timing: a command is registered when taken and applied to all cells in the
// apply state, where each cell compares in parallel and shifts by one slot;
// the result is presented in the cycle after the apply. The block takes no
// new command while one is in its apply state.
// Stall: the block takes a new command while a result still waits, but it
// holds that command in its apply cycle until the pending result has been
// transferred. The head fields read straight from the first cell, which
// cannot change while a result is pending.
// Reset: synchronous, active low; the queue comes up empty with no result
// pending.
// ---------------------------------------------------------------------------
`include "stable_priority_sorted_queue_macros.svh"

module stable_priority_sorted_queue
  import spsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] entry_id, [11:4] priority_req, [15:12] zero
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [2] head_valid, [6:3] head_id,
                                  // [14:7] head_priority, [19:15] entry_count,
                                  // [23:20] zero
);

  state_t              state_r, state_nxt;
  cmd_t                cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [PRIO_W-1:0]   prio_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_COUNT-1:0] present_r, present_nxt;
  status_t             status_r, status_c;
  logic                out_valid_r, out_valid_nxt;
  logic                in_fire, apply_fire, slot_free;
  cell_ctl_t           ctl;

  cell_data_t          cell_d [ENTRIES];
  logic [ENTRIES-1:0]  cell_gt;
  logic [ENTRIES:0]    passed;
  logic [ENTRIES-1:0]  cell_valid;
  logic                head_valid;

  assign in_fire    = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign apply_fire = (state_r == ST_APPLY) && slot_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_APPLY;
      ST_APPLY: if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_APPLY: in_tready = 1'b0;
      default:  in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_tuser);
      id_r   <= in_tdata[ID_W-1:0];
      prio_r <= in_tdata[ID_W +: PRIO_W];
    end
  end

  // Fullness is checked before duplication.
  always_comb begin
    priority if (cmd_r == CMD_ADD && count_r == CNT_W'(ENTRIES)) begin
      status_c = STATUS_FULL;
    end else if (cmd_r == CMD_ADD && present_r[id_r]) begin
      status_c = STATUS_DUP;
    end else if (cmd_r == CMD_REMOVE && !present_r[id_r]) begin
      status_c = STATUS_ABSENT;
    end else begin
      status_c = STATUS_OK;
    end
  end

  assign ctl.add_en    = apply_fire && (cmd_r == CMD_ADD) && (status_c == STATUS_OK);
  assign ctl.remove_en = apply_fire && (cmd_r == CMD_REMOVE) && (status_c == STATUS_OK);
  assign ctl.id        = id_r;
  assign ctl.prio      = prio_r;

  always_comb begin
    count_nxt   = count_r;
    present_nxt = present_r;
    if (ctl.add_en) begin
      count_nxt          = count_r + CNT_W'(1);
      present_nxt[id_r]  = 1'b1;
    end else if (ctl.remove_en) begin
      count_nxt          = count_r - CNT_W'(1);
      present_nxt[id_r]  = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status_r <= status_c;
    end
  end

  // Cell chain: slot 0 is the head of the queue.
  assign passed[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_data_t left_d;
    cell_data_t right_d;
    logic       left_gt;

    if (i == 0) begin : g_first
      assign left_d  = '0;
      assign left_gt = 1'b0;
    end else begin : g_inner
      assign left_d  = cell_d[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_body
      assign right_d = cell_d[i+1];
    end

    spsq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_d     (left_d),
      .left_gt    (left_gt),
      .right_d    (right_d),
      .passed_in  (passed[i]),
      .own_d      (cell_d[i]),
      .own_gt     (cell_gt[i]),
      .passed_out (passed[i+1])
    );

    assign cell_valid[i] = cell_d[i].valid;
  end

  assign head_valid = (count_r != '0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0,
                       count_r,
                       head_valid ? cell_d[0].prio : {PRIO_W{1'b0}},
                       head_valid ? cell_d[0].id : {ID_W{1'b0}},
                       head_valid,
                       status_r};

  `SPSQ_ASSERT_ALWAYS(a_count_cells, $countones(cell_valid) == count_r, "count disagrees with occupied cells")
  `SPSQ_ASSERT_ALWAYS(a_count_mask, $countones(present_r) == count_r, "count disagrees with presence mask")
  `SPSQ_ASSERT_IMPLY(a_head_match, head_valid, cell_d[0].valid && present_r[cell_d[0].id], "head cell not marked present")
  `SPSQ_ASSERT_IMPLY(a_hold_pending, out_valid_r && !out_tready, !ctl.add_en && !ctl.remove_en, "queue changed under a pending result")

endmodule
